// ----- hw/rtl/pfbtb_pkg.sv -----
// ---------------------------------------------------------------------------
// pfbtb_pkg
// Shared types and constants of the page framebuffer text blitter: command
// codes, back end states and the operation record passed through the queue.
// ---------------------------------------------------------------------------
package pfbtb_pkg;

  // widest frame address over the supported screen sizes (16 pages x 256)
  localparam int FB_ADDR_W   = 12;
  // widest font address over the supported font sizes (256 glyphs x 8)
  localparam int FONT_ADDR_W = 11;
  // depth of the queue between front and back
  localparam int Q_DEPTH     = 2;
  // glyph drawn for codes outside the font
  localparam logic [7:0] FALLBACK_CHAR = 8'd63;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RD_HI,
    BK_WR_HI,
    BK_WR_LO,
    BK_READ_WAIT
  } bk_state_t;

  // one classified transaction, ready for the back end
  typedef struct packed {
    cmd_t                   cmd;
    logic                   draw_en;
    logic                   lo_en;
    logic                   load_en;
    logic                   read_ok;
    logic [2:0]             shift;
    logic [3:0]             ncols;
    logic [FB_ADDR_W-1:0]   frame_addr;
    logic [FB_ADDR_W-1:0]   lo_addr;
    logic [FONT_ADDR_W-1:0] font_addr;
    logic [7:0]             bits;
  } op_t;

endpackage

// ----- hw/rtl/page_framebuffer_text_blitter.sv -----
// ---------------------------------------------------------------------------
// page_framebuffer_text_blitter
// Text blitter for a page-organised monochrome framebuffer with a loadable
// font: clear, draw character, load glyph column and read byte.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transaction.
//   The front end classifies it and drops it into a two-entry queue; in_stall
//   is high only while that queue is full.
//   Output channel (out_valid / out_stall) returns one byte for each read
//   command and nothing for the other commands, in command order.
//   Steps in the execution unit:
//     load glyph column  one font memory write
//     read byte          registered frame read, then the output register
//     clear              sweep of SCREEN_HEIGHT/8 * SCREEN_WIDTH bytes (1024 default)
//     draw character     glyph fetch, then an upper page read and write per visible
//                        column, plus a lower page write when the row spans two pages
//   Each draw column is a read-modify-write of the frame memory: a
//   registered read, then the write, one page byte at a time.
//   Reset: synchronous on rst_n; afterwards the unit sweeps the frame memory
//   to zero, SCREEN_HEIGHT/8 * SCREEN_WIDTH bytes (1024 default), before
//   it executes a command; up to two commands are queued meanwhile.
//   A stalled output holds its byte; draws, clears and loads behind it go on,
//   and a further read waits until the output register frees.
// ---------------------------------------------------------------------------
module page_framebuffer_text_blitter
  import pfbtb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int GLYPH_WIDTH   = 6,
  parameter int FIRST_CHAR    = 32,
  parameter int LAST_CHAR     = 126
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [7:0] in_x_position,
  input  logic [6:0] in_y_position,
  input  logic [7:0] in_char_code,
  input  logic [2:0] in_glyph_column,
  input  logic [7:0] in_glyph_bits,
  input  logic [9:0] in_read_address,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data
);

  logic q_full;
  logic q_push;
  op_t  q_op;
  logic q_pop;
  logic head_valid;
  op_t  head_op;

  // front end: accept and classify
  pfbtb_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .GLYPH_WIDTH   (GLYPH_WIDTH),
    .FIRST_CHAR    (FIRST_CHAR),
    .LAST_CHAR     (LAST_CHAR)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_x_position   (in_x_position),
    .in_y_position   (in_y_position),
    .in_char_code    (in_char_code),
    .in_glyph_column (in_glyph_column),
    .in_glyph_bits   (in_glyph_bits),
    .in_read_address (in_read_address),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_op            (q_op)
  );

  // decoupling queue
  pfbtb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // back end: execute against the memories
  pfbtb_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .GLYPH_WIDTH   (GLYPH_WIDTH),
    .FIRST_CHAR    (FIRST_CHAR),
    .LAST_CHAR     (LAST_CHAR)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_op       (head_op),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data)
  );

endmodule

// ----- hw/rtl/pfbtb_front.sv -----
// ---------------------------------------------------------------------------
// pfbtb_front
// Input side: takes a transaction when the queue has room and classifies it
// into an operation record (clipping, font fallback, page split, addresses).
// ---------------------------------------------------------------------------
module pfbtb_front
  import pfbtb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int GLYPH_WIDTH   = 6,
  parameter int FIRST_CHAR    = 32,
  parameter int LAST_CHAR     = 126
) (
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [7:0] in_x_position,
  input  logic [6:0] in_y_position,
  input  logic [7:0] in_char_code,
  input  logic [2:0] in_glyph_column,
  input  logic [7:0] in_glyph_bits,
  input  logic [9:0] in_read_address,
  input  logic       q_full,
  output logic       q_push,
  output op_t        q_op
);

  localparam int PAGE_COUNT  = SCREEN_HEIGHT / 8;
  localparam int FRAME_BYTES = PAGE_COUNT * SCREEN_WIDTH;

  cmd_t                   cmd;
  logic                   code_in_font;
  logic                   gcode_ok;
  logic [7:0]             gcode;
  logic [7:0]             code_off;
  logic [7:0]             glyph_off;
  logic [FONT_ADDR_W-1:0] glyph_base;
  logic [FONT_ADDR_W-1:0] load_addr;
  logic                   x_ok;
  logic                   y_ok;
  logic                   hi_ok;
  logic [3:0]             page;
  logic [2:0]             shift;
  logic [FB_ADDR_W-1:0]   hi_addr;
  logic [8:0]             room;

  // handshake: stall only on a full queue
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign cmd      = cmd_t'(in_command);

  // font range and fallback glyph
  always_comb begin
    code_in_font = ({1'b0, in_char_code} >= 9'(FIRST_CHAR)) &&
                   ({1'b0, in_char_code} <= 9'(LAST_CHAR));
    gcode        = code_in_font ? in_char_code : FALLBACK_CHAR;
    gcode_ok     = ({1'b0, gcode} >= 9'(FIRST_CHAR)) &&
                   ({1'b0, gcode} <= 9'(LAST_CHAR));
    code_off     = in_char_code - 8'(FIRST_CHAR);
    glyph_off    = gcode - 8'(FIRST_CHAR);
    glyph_base   = FONT_ADDR_W'(glyph_off) * FONT_ADDR_W'(GLYPH_WIDTH);
    load_addr    = FONT_ADDR_W'(code_off) * FONT_ADDR_W'(GLYPH_WIDTH) +
                   FONT_ADDR_W'(in_glyph_column);
  end

  // screen clipping and page split
  always_comb begin
    x_ok    = {1'b0, in_x_position} < 9'(SCREEN_WIDTH);
    y_ok    = {1'b0, in_y_position} < 8'(SCREEN_HEIGHT);
    page    = in_y_position[6:3];
    shift   = in_y_position[2:0];
    hi_ok   = {1'b0, page} < 5'(PAGE_COUNT);
    hi_addr = FB_ADDR_W'(page) * FB_ADDR_W'(SCREEN_WIDTH) + FB_ADDR_W'(in_x_position);
    room    = 9'(SCREEN_WIDTH) - {1'b0, in_x_position};
  end

  // operation record
  always_comb begin
    q_op.cmd        = cmd;
    q_op.draw_en    = x_ok && y_ok && hi_ok && gcode_ok;
    q_op.lo_en      = (shift != 3'd0) && (({1'b0, page} + 5'd1) < 5'(PAGE_COUNT));
    q_op.load_en    = code_in_font && ({1'b0, in_glyph_column} < 4'(GLYPH_WIDTH));
    q_op.read_ok    = {3'b000, in_read_address} < 13'(FRAME_BYTES);
    q_op.shift      = shift;
    q_op.ncols      = (room < 9'(GLYPH_WIDTH)) ? room[3:0] : 4'(GLYPH_WIDTH);
    q_op.frame_addr = (cmd == CMD_READ) ? FB_ADDR_W'(in_read_address) : hi_addr;
    q_op.lo_addr    = hi_addr + FB_ADDR_W'(SCREEN_WIDTH);
    q_op.font_addr  = (cmd == CMD_LOAD) ? load_addr : glyph_base;
    q_op.bits       = in_glyph_bits;
  end

endmodule

// ----- hw/rtl/pfbtb_queue.sv -----
// ---------------------------------------------------------------------------
// pfbtb_queue
// Short register queue of operation records between front and back end.
// ---------------------------------------------------------------------------
module pfbtb_queue
  import pfbtb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  op_t              entry_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = count_r == CNT_W'(Q_DEPTH);
  assign head_valid = count_r != '0;
  assign head_op    = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ----- hw/rtl/pfbtb_back.sv -----
// ---------------------------------------------------------------------------
// pfbtb_back
// Execution side: owns the frame and font memories, runs clear sweeps,
// per-column read-modify-write for drawing, font loads and byte reads.
// ---------------------------------------------------------------------------
module pfbtb_back
  import pfbtb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int GLYPH_WIDTH   = 6,
  parameter int FIRST_CHAR    = 32,
  parameter int LAST_CHAR     = 126
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  op_t        head_op,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data
);

  localparam int PAGE_COUNT  = SCREEN_HEIGHT / 8;
  localparam int FRAME_BYTES = PAGE_COUNT * SCREEN_WIDTH;
  localparam int FB_AW       = $clog2(FRAME_BYTES);
  localparam int GLYPH_COUNT = LAST_CHAR - FIRST_CHAR + 1;
  localparam int FONT_DEPTH  = (GLYPH_COUNT > 0) ? GLYPH_COUNT * GLYPH_WIDTH : 1;
  localparam int FONT_AW     = (FONT_DEPTH > 1) ? $clog2(FONT_DEPTH) : 1;

  logic [7:0] frame_mem [FRAME_BYTES];
  logic [7:0] font_mem  [FONT_DEPTH];

  bk_state_t          state_r;
  bk_state_t          state_nxt;
  logic [FB_AW-1:0]   clr_cnt_r;
  logic [FB_AW-1:0]   clr_cnt_nxt;
  logic [3:0]         col_r;
  logic [3:0]         col_nxt;
  logic [3:0]         ncols_r;
  logic [3:0]         ncols_nxt;
  logic [2:0]         shift_r;
  logic [2:0]         shift_nxt;
  logic               lo_en_r;
  logic               lo_en_nxt;
  logic               read_ok_r;
  logic               read_ok_nxt;
  logic [FB_AW-1:0]   hi_addr_r;
  logic [FB_AW-1:0]   hi_addr_nxt;
  logic [FB_AW-1:0]   lo_addr_r;
  logic [FB_AW-1:0]   lo_addr_nxt;
  logic [FONT_AW-1:0] font_base_r;
  logic [FONT_AW-1:0] font_base_nxt;
  logic [7:0]         bits_r;
  logic [7:0]         bits_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [7:0]         out_data_r;
  logic [7:0]         out_data_nxt;
  logic [7:0]         frame_q_r;
  logic [7:0]         font_q_r;

  logic               fb_we;
  logic [FB_AW-1:0]   fb_waddr;
  logic [7:0]         fb_wdata;
  logic               fb_re;
  logic [FB_AW-1:0]   fb_raddr;
  logic               ft_we;
  logic [FONT_AW-1:0] ft_waddr;
  logic               ft_re;
  logic [FONT_AW-1:0] ft_raddr;

  logic               out_free;
  logic               last_col;
  logic [3:0]         col_inc;

  assign out_free      = !out_valid_r || !out_stall;
  assign col_inc       = col_r + 4'd1;
  assign last_col      = col_inc >= ncols_r;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_cnt_r == FB_AW'(FRAME_BYTES - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (head_valid) begin
          case (head_op.cmd)
            CMD_CLEAR: state_nxt = BK_CLEAR;
            CMD_DRAW:  state_nxt = head_op.draw_en ? BK_RD_HI : BK_IDLE;
            CMD_READ:  state_nxt = out_free ? BK_READ_WAIT : BK_IDLE;
            default:   state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_RD_HI: state_nxt = BK_WR_HI;
      BK_WR_HI: begin
        if (lo_en_r) begin
          state_nxt = BK_WR_LO;
        end else begin
          state_nxt = last_col ? BK_IDLE : BK_RD_HI;
        end
      end
      BK_WR_LO:     state_nxt = last_col ? BK_IDLE : BK_RD_HI;
      BK_READ_WAIT: state_nxt = BK_IDLE;
      default:      state_nxt = BK_IDLE;
    endcase
  end

  // memory controls and datapath register updates
  always_comb begin
    pop           = 1'b0;
    fb_we         = 1'b0;
    fb_waddr      = hi_addr_r + FB_AW'(col_r);
    fb_wdata      = 8'h00;
    fb_re         = 1'b0;
    fb_raddr      = hi_addr_r + FB_AW'(col_r);
    ft_we         = 1'b0;
    ft_waddr      = FONT_AW'(head_op.font_addr);
    ft_re         = 1'b0;
    ft_raddr      = font_base_r + FONT_AW'(col_inc);
    clr_cnt_nxt   = clr_cnt_r;
    col_nxt       = col_r;
    ncols_nxt     = ncols_r;
    shift_nxt     = shift_r;
    lo_en_nxt     = lo_en_r;
    read_ok_nxt   = read_ok_r;
    hi_addr_nxt   = hi_addr_r;
    lo_addr_nxt   = lo_addr_r;
    font_base_nxt = font_base_r;
    bits_nxt      = bits_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      BK_CLEAR: begin
        // sweep one byte a cycle
        fb_we       = 1'b1;
        fb_waddr    = clr_cnt_r;
        fb_wdata    = 8'h00;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      BK_IDLE: begin
        if (head_valid) begin
          case (head_op.cmd)
            CMD_CLEAR: begin
              pop         = 1'b1;
              clr_cnt_nxt = '0;
            end
            CMD_DRAW: begin
              // latch the draw and fetch the first glyph column
              pop           = 1'b1;
              ft_re         = head_op.draw_en;
              ft_raddr      = FONT_AW'(head_op.font_addr);
              col_nxt       = 4'd0;
              ncols_nxt     = head_op.ncols;
              shift_nxt     = head_op.shift;
              lo_en_nxt     = head_op.lo_en;
              hi_addr_nxt   = FB_AW'(head_op.frame_addr);
              lo_addr_nxt   = FB_AW'(head_op.lo_addr);
              font_base_nxt = FONT_AW'(head_op.font_addr);
            end
            CMD_LOAD: begin
              pop   = 1'b1;
              ft_we = head_op.load_en;
            end
            CMD_READ: begin
              // wait for a free output register
              if (out_free) begin
                pop         = 1'b1;
                fb_re       = head_op.read_ok;
                fb_raddr    = FB_AW'(head_op.frame_addr);
                read_ok_nxt = head_op.read_ok;
              end
            end
            default: pop = 1'b0;
          endcase
        end
      end
      BK_RD_HI: begin
        // take the glyph column, read the upper page, prefetch next column
        bits_nxt = font_q_r;
        fb_re    = 1'b1;
        ft_re    = !last_col;
      end
      BK_WR_HI: begin
        fb_we    = 1'b1;
        fb_wdata = frame_q_r | 8'(bits_r << shift_r);
        if (lo_en_r) begin
          fb_re    = 1'b1;
          fb_raddr = lo_addr_r + FB_AW'(col_r);
        end else begin
          col_nxt = col_inc;
        end
      end
      BK_WR_LO: begin
        fb_we    = 1'b1;
        fb_waddr = lo_addr_r + FB_AW'(col_r);
        fb_wdata = frame_q_r | 8'(bits_r >> (4'd8 - {1'b0, shift_r}));
        col_nxt  = col_inc;
      end
      BK_READ_WAIT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = read_ok_r ? frame_q_r : 8'h00;
      end
      default: pop = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    col_r       <= col_nxt;
    ncols_r     <= ncols_nxt;
    shift_r     <= shift_nxt;
    lo_en_r     <= lo_en_nxt;
    read_ok_r   <= read_ok_nxt;
    hi_addr_r   <= hi_addr_nxt;
    lo_addr_r   <= lo_addr_nxt;
    font_base_r <= font_base_nxt;
    bits_r      <= bits_nxt;
    out_data_r  <= out_data_nxt;
  end

  // frame memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (fb_we) begin
      frame_mem[fb_waddr] <= fb_wdata;
    end
    if (fb_re) begin
      frame_q_r <= frame_mem[fb_raddr];
    end
  end

  // font memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (ft_we) begin
      font_mem[ft_waddr] <= head_op.bits;
    end
    if (ft_re) begin
      font_q_r <= font_mem[ft_raddr];
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Checks the page framebuffer text blitter against a behavioral mirror of
// its frame and font stores: every read byte is compared in order, under
// random idling on both channels and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_top;
  import pfbtb_pkg::*;

  // screen and font geometry of the default build
  localparam int SCREEN_W    = 128;
  localparam int SCREEN_H    = 64;
  localparam int GLYPH_W     = 6;
  localparam int FIRST_CH    = 32;
  localparam int LAST_CH     = 126;
  localparam int PAGES       = SCREEN_H / 8;
  localparam int FRAME_BYTES = PAGES * SCREEN_W;
  localparam int GLYPHS      = LAST_CH - FIRST_CH + 1;
  localparam int FONT_BYTES  = GLYPHS * GLYPH_W;

  // run shape
  localparam int RANDOM_ITEMS = 800;
  localparam int IDLE_PCT     = 34;
  localparam int QUIET_FROM   = 4000;
  localparam int QUIET_TO     = 6000;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 12000;
  localparam int DRAIN_CYCLES = 1200;

  typedef struct {
    cmd_t       command;
    logic [7:0] x_position;
    logic [6:0] y_position;
    logic [7:0] char_code;
    logic [2:0] glyph_column;
    logic [7:0] glyph_bits;
    logic [9:0] read_address;
  } blit_cmd_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_command = CMD_CLEAR;
  logic [7:0] in_x_position = '0;
  logic [6:0] in_y_position = '0;
  logic [7:0] in_char_code = '0;
  logic [2:0] in_glyph_column = '0;
  logic [7:0] in_glyph_bits = '0;
  logic [9:0] in_read_address = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;

  page_framebuffer_text_blitter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_x_position   (in_x_position),
    .in_y_position   (in_y_position),
    .in_char_code    (in_char_code),
    .in_glyph_column (in_glyph_column),
    .in_glyph_bits   (in_glyph_bits),
    .in_read_address (in_read_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data)
  );

  always #6 clk = ~clk;

  // mirror of the block's stores
  logic [7:0] frame_mirror [FRAME_BYTES];
  logic [7:0] font_mirror [FONT_BYTES];
  logic [7:0] expected_bytes [$];

  // generator side: which font entries have been loaded so far
  bit          font_written [FONT_BYTES];
  bit          glyph_ready [GLYPHS];
  int unsigned ready_codes [$];

  blit_cmd_t   cmd_backlog [$];
  blit_cmd_t   cur_cmd;
  int unsigned n_items_total = 0;
  int unsigned n_in_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_run = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic        quiet;

  assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

  function automatic bit in_font(int unsigned code);
    return (code >= FIRST_CH) && (code <= LAST_CH);
  endfunction

  // apply one accepted transaction to the mirror, queue the byte a read returns
  task automatic blit_model_apply(input blit_cmd_t c);
    int unsigned code;
    int unsigned base;
    int unsigned gx;
    int unsigned page;
    int unsigned col;
    logic [15:0] spread;
    logic [2:0]  shift;
    case (c.command)
      CMD_CLEAR: begin
        foreach (frame_mirror[i]) frame_mirror[i] = 8'h00;
      end
      CMD_DRAW: begin
        code = 32'(c.char_code);
        if (!in_font(code)) code = 32'(FALLBACK_CHAR);
        if (c.x_position < SCREEN_W && c.y_position < SCREEN_H && in_font(code)) begin
          base  = (code - FIRST_CH) * GLYPH_W;
          page  = c.y_position / 8;
          shift = c.y_position[2:0];
          for (col = 0; col < GLYPH_W; col++) begin
            gx = c.x_position + col;
            if (gx < SCREEN_W) begin
              // upper part lands in this page, the spill in the next one
              spread = {8'h00, font_mirror[base + col]} << shift;
              frame_mirror[page * SCREEN_W + gx] |= spread[7:0];
              if (shift != 0 && page + 1 < PAGES)
                frame_mirror[(page + 1) * SCREEN_W + gx] |= spread[15:8];
            end
          end
        end
      end
      CMD_LOAD: begin
        if (in_font(c.char_code) && c.glyph_column < GLYPH_W)
          font_mirror[(c.char_code - FIRST_CH) * GLYPH_W + c.glyph_column] = c.glyph_bits;
      end
      default: begin
        if (c.read_address < FRAME_BYTES) expected_bytes.push_back(frame_mirror[c.read_address]);
        else expected_bytes.push_back(8'h00);
      end
    endcase
  endtask

  // random filler for the fields a command does not use
  function automatic blit_cmd_t noise_cmd();
    blit_cmd_t c;
    c.command      = CMD_CLEAR;
    c.x_position   = 8'($urandom_range(0, 255));
    c.y_position   = 7'($urandom_range(0, 127));
    c.char_code    = 8'($urandom_range(0, 255));
    c.glyph_column = 3'($urandom_range(0, 7));
    c.glyph_bits   = 8'($urandom_range(0, 255));
    c.read_address = 10'($urandom_range(0, 1023));
    return c;
  endfunction

  function automatic void push_clear();
    blit_cmd_t c;
    c = noise_cmd();
    c.command = CMD_CLEAR;
    cmd_backlog.push_back(c);
  endfunction

  function automatic void push_draw(int unsigned x, int unsigned y, int unsigned code);
    blit_cmd_t c;
    c = noise_cmd();
    c.command    = CMD_DRAW;
    c.x_position = 8'(x);
    c.y_position = 7'(y);
    c.char_code  = 8'(code);
    cmd_backlog.push_back(c);
  endfunction

  function automatic void push_read(int unsigned addr);
    blit_cmd_t c;
    c = noise_cmd();
    c.command      = CMD_READ;
    c.read_address = 10'(addr);
    cmd_backlog.push_back(c);
  endfunction

  // font load; a glyph becomes drawable once all its columns are loaded
  function automatic void push_load(int unsigned code, int unsigned column, logic [7:0] bits);
    blit_cmd_t   c;
    int unsigned g;
    bit          full;
    c = noise_cmd();
    c.command      = CMD_LOAD;
    c.char_code    = 8'(code);
    c.glyph_column = 3'(column);
    c.glyph_bits   = bits;
    cmd_backlog.push_back(c);
    if (in_font(code) && column < GLYPH_W) begin
      g = code - FIRST_CH;
      font_written[g * GLYPH_W + column] = 1'b1;
      full = 1'b1;
      for (int unsigned k = 0; k < GLYPH_W; k++) full &= font_written[g * GLYPH_W + k];
      if (full && !glyph_ready[g]) begin
        glyph_ready[g] = 1'b1;
        ready_codes.push_back(code);
      end
    end
  endfunction

  initial begin
    int unsigned n_random;
    int unsigned pick;
    int unsigned code;
    int unsigned col;
    int unsigned x;
    int unsigned y;
    int unsigned last_x;
    int unsigned last_y;
    int unsigned addr;
    n_random = 0;
    last_x   = 0;
    last_y   = 0;
    foreach (frame_mirror[i]) frame_mirror[i] = 8'h00;
    foreach (font_mirror[i]) font_mirror[i] = 8'h00;

    // directed: fallback glyph, bad loads, edges, clear
    push_read(0);
    push_load(FALLBACK_CHAR, 0, 8'hFF);
    push_load(FALLBACK_CHAR, 1, 8'h81);
    push_load(FALLBACK_CHAR, 2, 8'h00);
    push_load(FALLBACK_CHAR, 3, 8'hA5);
    push_load(FALLBACK_CHAR, 4, 8'h5A);
    push_load(FALLBACK_CHAR, 5, 8'h7E);
    push_load(FIRST_CH - 1, 0, 8'hFF);
    push_load(LAST_CH + 1, 2, 8'hFF);
    push_load(FALLBACK_CHAR, 6, 8'h00);
    push_load(FALLBACK_CHAR, 7, 8'h00);
    push_draw(0, 0, 0);
    push_draw(0, 0, 255);
    push_draw(125, 3, FALLBACK_CHAR);
    push_draw(200, 0, FALLBACK_CHAR);
    push_draw(127, 61, FALLBACK_CHAR);
    push_draw(10, 64, FALLBACK_CHAR);
    push_draw(20, 127, FALLBACK_CHAR);
    push_read(0);
    push_read(125);
    push_read(127);
    push_read(FRAME_BYTES - 1);
    push_clear();
    push_read(0);
    push_read(FRAME_BYTES - 1);

    // random: mostly whole glyph loads, draws of loaded glyphs and reads
    while (n_random < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        code = $urandom_range(FIRST_CH, LAST_CH);
        for (col = 0; col < GLYPH_W; col++) push_load(code, col, 8'($urandom_range(0, 255)));
        n_random += GLYPH_W;
      end else if (pick < 22) begin
        // single load, often out of range and so ignored
        code = $urandom_range(0, 255);
        col  = $urandom_range(0, 7);
        push_load(code, col, 8'($urandom_range(0, 255)));
        if (in_font(code) && col < GLYPH_W) n_random++;
      end else if (pick < 24) begin
        push_clear();
        n_random++;
      end else if (pick < 60) begin
        if (ready_codes.size() > 0 && $urandom_range(0, 3) != 0) begin
          code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
        end else begin
          code = $urandom_range(0, 255);
          if (in_font(code) && !glyph_ready[code - FIRST_CH]) code = FALLBACK_CHAR;
        end
        x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, SCREEN_W - 1);
        y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, SCREEN_H - 1);
        push_draw(x, y, code);
        last_x = x;
        last_y = y;
        n_random++;
      end else begin
        // half the reads land on the last drawn character
        if ($urandom_range(0, 1) == 1)
          addr = ((last_y / 8 + $urandom_range(0, 1)) % PAGES) * SCREEN_W
                 + (last_x + $urandom_range(0, 7)) % SCREEN_W;
        else
          addr = $urandom_range(0, FRAME_BYTES - 1);
        push_read(addr);
        n_random++;
      end
    end
    n_items_total = cmd_backlog.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (n_in_accepted < n_items_total || expected_bytes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // driver: one transaction per handshake, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        blit_model_apply(cur_cmd);
        n_in_accepted <= n_in_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_cmd = cmd_backlog.pop_front();
          in_valid        <= 1'b1;
          in_command      <= cur_cmd.command;
          in_x_position   <= cur_cmd.x_position;
          in_y_position   <= cur_cmd.y_position;
          in_char_code    <= cur_cmd.char_code;
          in_glyph_column <= cur_cmd.glyph_column;
          in_glyph_bits   <= cur_cmd.glyph_bits;
          in_read_address <= cur_cmd.read_address;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && n_in_accepted >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // monitor: compare each returned byte with the oldest expectation
  always @(posedge clk) begin : read_check
    logic [7:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("read_data: expected nothing, actual %02h", out_read_data);
        n_errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_read_data !== want) begin
          $error("read_data: expected %02h, actual %02h", want, out_read_data);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction while work is outstanding
  always @(posedge clk) begin
    if (rst_n && (n_in_accepted < n_items_total || expected_bytes.size() > 0)
        && !(in_valid && !in_stall) && !(out_valid && !out_stall)) begin
      idle_run = idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end else begin
      idle_run = 0;
    end
  end

endmodule

// ----- files.f -----
hw/rtl/pfbtb_pkg.sv
hw/rtl/pfbtb_front.sv
hw/rtl/pfbtb_queue.sv
hw/rtl/pfbtb_back.sv
hw/rtl/page_framebuffer_text_blitter.sv
verif/tb_top.sv
